// File: hdl/clover_field_strength_assert.svh
`ifndef CLOVER_FIELD_STRENGTH_ASSERT_SVH
`define CLOVER_FIELD_STRENGTH_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked at the clock after the antecedent
`define CFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/cfs_pkg.sv
package cfs_pkg;
	localparam int NUM_LINKS = 12;
	localparam int LINK_ENTRIES = 108;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLEAR, ST_MUL, ST_FIN, ST_ADD, ST_OUT
	} state_t;

	typedef struct packed {
		logic [3:0] slot;
		logic       conj;
		logic       from_work;
	} operand_t;

	// operand sequence for the twelve chained products
	function automatic operand_t op_a(input logic [3:0] p);
		operand_t o;
		o = '{slot: 4'd0, conj: 1'b0, from_work: 1'b1};
		unique case (p)
			4'd0: o = '{slot: 4'd0, conj: 1'b0, from_work: 1'b0};
			4'd3: o = '{slot: 4'd3, conj: 1'b0, from_work: 1'b0};
			4'd6: o = '{slot: 4'd6, conj: 1'b1, from_work: 1'b0};
			4'd9: o = '{slot: 4'd9, conj: 1'b1, from_work: 1'b0};
			default: o = '{slot: 4'd0, conj: 1'b0, from_work: 1'b1};
		endcase
		return o;
	endfunction

	function automatic operand_t op_b(input logic [3:0] p);
		operand_t o;
		o = '{slot: 4'd0, conj: 1'b0, from_work: 1'b0};
		unique case (p)
			4'd0: o.slot = 4'd1;
			4'd1: begin o.slot = 4'd2; o.conj = 1'b1; end
			4'd2: begin o.slot = 4'd3; o.conj = 1'b1; end
			4'd3: begin o.slot = 4'd4; o.conj = 1'b1; end
			4'd4: begin o.slot = 4'd5; o.conj = 1'b1; end
			4'd5: o.slot = 4'd6;
			4'd6: begin o.slot = 4'd7; o.conj = 1'b1; end
			4'd7: o.slot = 4'd8;
			4'd8: o.slot = 4'd9;
			4'd9: o.slot = 4'd10;
			4'd10: o.slot = 4'd11;
			default: begin o.slot = 4'd0; o.conj = 1'b1; end
		endcase
		return o;
	endfunction
endpackage

// File: hdl/clover_field_strength.sv
// channel   | dir | transfer when       | fields
// ----------+-----+---------------------+-------------------------------------------
// element   | in  | start && !busy      | link_slot row col elem_re elem_im end_of_set
// result    | out | strobe              | out_row out_col out_re out_im out_last
//
// an element without end mark is written (when in range) and leaves busy low
// an end-marked element keeps busy high through clear, then per product element three steps
// (two fetches, four terms each), finish and store, then the nine result elements
// results stream out one per cycle at the end, no stall from the receiver
// reset clears control and the sum registers; link and work storage are undefined until written
module clover_field_strength #(
	parameter int FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         link_slot,
	input  logic [1:0]         row,
	input  logic [1:0]         col,
	input  logic signed [31:0] elem_re,
	input  logic signed [31:0] elem_im,
	input  logic               end_of_set,
	output logic               strobe,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] out_re,
	output logic signed [31:0] out_im,
	output logic               out_last
);
	cfs_pkg::state_t state_q, state_d;

	logic [63:0] link_mem [cfs_pkg::LINK_ENTRIES];
	logic [63:0] link_rd_q;
	logic [6:0]  link_addr;
	logic [63:0] work_q [18];
	logic signed [33:0] sum_re_q [9];
	logic signed [33:0] sum_im_q [9];

	logic [3:0] prod_q;
	logic [1:0] i_q, j_q, k_q;
	logic [1:0] t_q;   // term: 0 ar*br, 1 -ai*bi, 2 ar*bi, 3 ai*br
	logic [2:0] ph_q;
	logic [3:0] out_q;
	logic       fin_q;
	logic       wsel_q;

	cfs_pkg::operand_t oa, ob;
	logic [1:0] ar, ac, br, bc;
	logic [63:0] a_val, b_val;
	logic signed [31:0] a_part, b_part;
	logic        a_neg_im, b_neg_im;
	logic        mac_en, mac_clr, mac_neg;
	logic        term_last;
	logic signed [31:0] mac_re, mac_im, mac_result;
	logic signed [31:0] fin_re_q;
	logic        wr;

	assign wr = start && !busy && link_slot < 4'(cfs_pkg::NUM_LINKS)
		&& row < 2'd3 && col < 2'd3;

	always_comb begin
		oa = cfs_pkg::op_a(prod_q);
		ob = cfs_pkg::op_b(prod_q);
		ar = oa.conj ? k_q : i_q;
		ac = oa.conj ? i_q : k_q;
		br = ob.conj ? j_q : k_q;
		bc = ob.conj ? k_q : j_q;
		link_addr = 7'(ob.slot) * 7'd9 + 7'(br) * 7'd3 + 7'(bc);
		if (state_q == cfs_pkg::ST_IDLE)
			link_addr = 7'(link_slot) * 7'd9 + 7'(row) * 7'd3 + 7'(col);
		else if (ph_q == 3'd0 && !oa.from_work)
			link_addr = 7'(oa.slot) * 7'd9 + 7'(ar) * 7'd3 + 7'(ac);
	end

	// link ram, one read port alternating between a and b operands
	logic [63:0] a_hold_q;
	always_ff @(posedge clk) begin
		if (wr) link_mem[link_addr] <= {elem_re, elem_im};
		link_rd_q <= link_mem[link_addr];
	end

	// phase: a step fetches a, the next fetches b, then 4 terms
	always_comb begin
		a_val = oa.from_work ? work_q[{3'd0, wsel_q} * 5'd9 + 5'(ar) * 5'd3 + 5'(ac)]
			: a_hold_q;
		b_val = link_rd_q;
		a_neg_im = oa.conj;
		b_neg_im = ob.conj;
		unique case (t_q)
			2'd0: begin a_part = a_val[63:32]; b_part = b_val[63:32]; mac_neg = 1'b0; end
			2'd1: begin a_part = a_val[31:0]; b_part = b_val[31:0];
				mac_neg = !(a_neg_im ^ b_neg_im); end
			2'd2: begin a_part = a_val[63:32]; b_part = b_val[31:0]; mac_neg = b_neg_im; end
			default: begin a_part = a_val[31:0]; b_part = b_val[63:32]; mac_neg = a_neg_im; end
		endcase
		mac_en = state_q == cfs_pkg::ST_MUL && ph_q >= 3'd2;
		term_last = t_q == 2'd3 && k_q == 2'd2;
	end

	logic re_en, im_en;
	assign re_en = mac_en && !t_q[1];
	assign im_en = mac_en && t_q[1];
	assign mac_clr = state_q != cfs_pkg::ST_MUL && state_q != cfs_pkg::ST_FIN;

	cfs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_re (
		.clk(clk), .clr(mac_clr), .en(re_en), .neg(mac_neg),
		.a(a_part), .b(b_part), .result(mac_re));
	cfs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac_im (
		.clk(clk), .clr(mac_clr), .en(im_en), .neg(mac_neg),
		.a(a_part), .b(b_part), .result(mac_im));
	assign mac_result = mac_re;

	logic [3:0] e_idx;
	assign e_idx = 4'(i_q) * 4'd3 + 4'(j_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfs_pkg::ST_IDLE: if (start && end_of_set) state_d = cfs_pkg::ST_CLEAR;
			cfs_pkg::ST_CLEAR: state_d = cfs_pkg::ST_MUL;
			cfs_pkg::ST_MUL: if (mac_en && term_last) state_d = cfs_pkg::ST_FIN;
			cfs_pkg::ST_FIN: if (fin_q) state_d = cfs_pkg::ST_ADD;
			cfs_pkg::ST_ADD: begin
				if (e_idx == 4'd8 && prod_q == 4'd11) state_d = cfs_pkg::ST_OUT;
				else state_d = cfs_pkg::ST_MUL;
			end
			cfs_pkg::ST_OUT: if (out_q == 4'd8) state_d = cfs_pkg::ST_IDLE;
			default: state_d = cfs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfs_pkg::ST_IDLE;
			prod_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; t_q <= '0;
			ph_q <= '0; out_q <= '0; fin_q <= 1'b0; wsel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				cfs_pkg::ST_CLEAR: begin
					prod_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; t_q <= '0;
					ph_q <= '0; wsel_q <= 1'b0; out_q <= '0;
				end
				cfs_pkg::ST_MUL: begin
					// ph 0: addr a, 1: addr b / a lands, 2..5: terms (b data held)
					if (ph_q < 3'd5) ph_q <= ph_q + 3'd1;
					else begin
						ph_q <= '0;
						if (k_q == 2'd2) k_q <= '0; else k_q <= k_q + 2'd1;
					end
					if (ph_q >= 3'd2) t_q <= t_q + 2'd1;
					fin_q <= 1'b0;
				end
				cfs_pkg::ST_FIN: fin_q <= 1'b1;
				cfs_pkg::ST_ADD: begin
					fin_q <= 1'b0;
					if (j_q == 2'd2) begin
						j_q <= '0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							prod_q <= prod_q + 4'd1;
							wsel_q <= !wsel_q;
						end else i_q <= i_q + 2'd1;
					end else j_q <= j_q + 2'd1;
				end
				cfs_pkg::ST_OUT: out_q <= out_q + 4'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cfs_pkg::ST_MUL && ph_q == 3'd1) a_hold_q <= link_rd_q;
		if (state_q == cfs_pkg::ST_FIN) fin_re_q <= mac_result;
		if (state_q == cfs_pkg::ST_ADD) begin
			work_q[{3'd0, !wsel_q} * 5'd9 + 5'(e_idx)] <= {fin_re_q, mac_im};
		end
	end

	logic leaf_end;
	assign leaf_end = prod_q == 4'd2 || prod_q == 4'd5 || prod_q == 4'd8 || prod_q == 4'd11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 9; n++) begin
				sum_re_q[n] <= '0;
				sum_im_q[n] <= '0;
			end
		end else if (state_q == cfs_pkg::ST_CLEAR) begin
			for (int n = 0; n < 9; n++) begin
				sum_re_q[n] <= '0;
				sum_im_q[n] <= '0;
			end
		end else if (state_q == cfs_pkg::ST_ADD && leaf_end) begin
			sum_re_q[e_idx] <= sum_re_q[e_idx] + 34'(fin_re_q);
			sum_im_q[e_idx] <= sum_im_q[e_idx] + 34'(mac_im);
		end
	end

	// output: one element per cycle of (S - S')/4
	logic [1:0] orow, ocol;
	logic signed [34:0] dr, di, vr, vi;
	always_comb begin
		orow = out_q >= 4'd6 ? 2'd2 : (out_q >= 4'd3 ? 2'd1 : 2'd0);
		ocol = 2'(out_q - 4'(orow) * 4'd3);
		dr = 35'(sum_re_q[4'(orow) * 4'd3 + 4'(ocol)])
			- 35'(sum_re_q[4'(ocol) * 4'd3 + 4'(orow)]);
		di = 35'(sum_im_q[4'(orow) * 4'd3 + 4'(ocol)])
			+ 35'(sum_im_q[4'(ocol) * 4'd3 + 4'(orow)]);
		vr = (dr + 35'sd2) >>> 2;
		vi = (di + 35'sd2) >>> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= state_q == cfs_pkg::ST_OUT;
	end

	always_ff @(posedge clk) begin
		out_row <= orow;
		out_col <= ocol;
		out_re <= vr > 35'sd2147483647 ? 32'sh7fffffff
			: (vr < -35'sd2147483648 ? 32'sh80000000 : vr[31:0]);
		out_im <= vi > 35'sd2147483647 ? 32'sh7fffffff
			: (vi < -35'sd2147483648 ? 32'sh80000000 : vi[31:0]);
		out_last <= out_q == 4'd8;
	end

	assign busy = state_q != cfs_pkg::ST_IDLE;
endmodule

// File: hdl/cfs_mac.sv
// one signed 32x32 product a cycle, accumulated while enabled, into split high/low accumulators
module cfs_mac #(
	parameter int FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               clr,
	input  logic               en,
	input  logic               neg,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [31:0] result
);
	logic signed [63:0] prod_s1;
	logic               neg_s1, en_s1;
	logic signed [63:0] hi_q;
	logic signed [40:0] lo_q;
	logic signed [63:0] p;
	logic signed [63:0] h;
	logic signed [63:0] l;
	logic signed [63:0] r;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		neg_s1  <= neg;
		en_s1   <= en;
	end

	always_comb begin
		p = neg_s1 ? -prod_s1 : prod_s1;
		h = p >>> FRAC_BITS;
		l = p - (h <<< FRAC_BITS);
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (en_s1) begin
			hi_q <= hi_q + h;
			lo_q <= lo_q + 41'(l);
		end
	end

	always_comb begin
		r = hi_q + 64'((lo_q + (41'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
		if (r > 64'sd2147483647) result = 32'sh7fffffff;
		else if (r < -64'sd2147483648) result = 32'sh80000000;
		else result = r[31:0];
	end
endmodule

// File: hdl/cfs_checker.sv
`include "clover_field_strength_assert.svh"
module cfs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic end_of_set,
	input logic strobe,
	input logic out_last
);
	`CFS_ASSERT_IMP(a_strobe_busy, strobe && !out_last, busy, "strobe while idle")
	`CFS_ASSERT_NXT(a_last_ends, strobe && out_last, !strobe, "strobe after last")
	`CFS_ASSERT_NXT(a_end_busy, start && !busy && end_of_set, busy, "no busy after end")
	`CFS_ASSERT_NXT(a_plain_idle, start && !busy && !end_of_set, !busy && !strobe,
		"busy after plain element")
endmodule

bind clover_field_strength cfs_checker u_cfs_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.end_of_set(end_of_set), .strobe(strobe), .out_last(out_last));

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	localparam int FRAC = 30;
	localparam int LINKS = cfs_pkg::NUM_LINKS;
	localparam int STORE = cfs_pkg::LINK_ENTRIES;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		longint re;
		longint im;
	} cplx_t;

	typedef struct {
		logic [1:0]  r;
		logic [1:0]  c;
		logic [31:0] re;
		logic [31:0] im;
		logic        last;
	} field_elem_t;

	class field_strength_sb;
		cplx_t       links[STORE];
		field_elem_t pending[$];
		int          errors;

		function longint sat32(longint x);
			if (x > 64'sh7fffffff) return 64'sh7fffffff;
			if (x < -64'sh80000000) return -64'sh80000000;
			return x;
		endfunction

		// split each partial product so the six-term sum stays within 64 bits
		function void acc(inout longint hi, inout longint lo, input longint p);
			longint h;
			h = p >>> FRAC;
			hi += h;
			lo += p - (h <<< FRAC);
		endfunction

		function longint fin(longint hi, longint lo);
			return sat32(hi + ((lo + (64'sd1 <<< (FRAC - 1))) >>> FRAC));
		endfunction

		function void mat_mul(output cplx_t r[9], input cplx_t a[9], input bit ca,
				input cplx_t b[9], input bit cb);
			longint hr, lr, hi, li, ar, ai, br, bi;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					hr = 0; lr = 0; hi = 0; li = 0;
					for (int k = 0; k < 3; k++) begin
						if (ca) begin
							ar = a[k*3+i].re; ai = -a[k*3+i].im;
						end else begin
							ar = a[i*3+k].re; ai = a[i*3+k].im;
						end
						if (cb) begin
							br = b[j*3+k].re; bi = -b[j*3+k].im;
						end else begin
							br = b[k*3+j].re; bi = b[k*3+j].im;
						end
						acc(hr, lr, ar * br);
						acc(hr, lr, -(ai * bi));
						acc(hi, li, ar * bi);
						acc(hi, li, ai * br);
					end
					r[i*3+j].re = fin(hr, lr);
					r[i*3+j].im = fin(hi, li);
				end
		endfunction

		function void link_mat(int s, output cplx_t m[9]);
			for (int e = 0; e < 9; e++) m[e] = links[s*9+e];
		endfunction

		function void add_leaf(inout cplx_t sum[9], input int s0, bit c0, int s1, bit c1,
				int s2, bit c2, int s3, bit c3);
			cplx_t a[9], b[9], t1[9], t2[9];
			link_mat(s0, a);
			link_mat(s1, b);
			mat_mul(t1, a, c0, b, c1);
			link_mat(s2, b);
			mat_mul(t2, t1, 1'b0, b, c2);
			link_mat(s3, b);
			mat_mul(t1, t2, 1'b0, b, c3);
			for (int e = 0; e < 9; e++) begin
				sum[e].re += t1[e].re;
				sum[e].im += t1[e].im;
			end
		endfunction

		function void note(logic [3:0] slot, logic [1:0] r, logic [1:0] c,
				logic signed [31:0] re, logic signed [31:0] im, logic eos);
			cplx_t sum[9];
			field_elem_t x;
			longint dr, di;
			if (slot < LINKS && r < 3 && c < 3) begin
				links[slot*9+r*3+c].re = re;
				links[slot*9+r*3+c].im = im;
			end
			if (!eos) return;
			for (int e = 0; e < 9; e++) sum[e] = '{0, 0};
			add_leaf(sum, 0, 1'b0, 1, 1'b0, 2, 1'b1, 3, 1'b1);
			add_leaf(sum, 3, 1'b0, 4, 1'b1, 5, 1'b1, 6, 1'b0);
			add_leaf(sum, 6, 1'b1, 7, 1'b1, 8, 1'b0, 9, 1'b0);
			add_leaf(sum, 9, 1'b1, 10, 1'b0, 11, 1'b0, 0, 1'b1);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					dr = sum[i*3+j].re - sum[j*3+i].re;
					di = sum[i*3+j].im + sum[j*3+i].im;
					x.r = 2'(i);
					x.c = 2'(j);
					x.re = 32'(sat32((dr + 2) >>> 2));
					x.im = 32'(sat32((di + 2) >>> 2));
					x.last = (i == 2 && j == 2);
					pending.push_back(x);
				end
		endfunction

		task report_mismatch(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check(field_elem_t got);
			field_elem_t x;
			if (pending.size() == 0) begin
				report_mismatch("result element with none expected");
				return;
			end
			x = pending.pop_front();
			if (got.r !== x.r || got.c !== x.c || got.re !== x.re || got.im !== x.im
					|| got.last !== x.last)
				report_mismatch($sformatf(
					"got (%0d,%0d) %h %h last %b, want (%0d,%0d) %h %h last %b",
					got.r, got.c, got.re, got.im, got.last,
					x.r, x.c, x.re, x.im, x.last));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [3:0]         link_slot;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] elem_re;
	logic signed [31:0] elem_im;
	logic               end_of_set;
	logic               strobe;
	logic [1:0]         out_row;
	logic [1:0]         out_col;
	logic signed [31:0] out_re;
	logic signed [31:0] out_im;
	logic               out_last;

	field_strength_sb sb = new();
	int gap_pct;
	int sent;
	int cycles = 0;

	clover_field_strength #(.FRAC_BITS(FRAC)) dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check('{out_row, out_col, out_re, out_im, out_last});
	end

	function logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'h40000000;
			default: return $urandom;
		endcase
	endfunction

	// one element transfer; start stays high into the next item when no gap is drawn
	task automatic send_elem(logic [3:0] s, logic [1:0] r, logic [1:0] c,
			logic [31:0] re, logic [31:0] im, logic eos);
		start <= 1'b1;
		link_slot <= s;
		row <= r;
		col <= c;
		elem_re <= re;
		elem_im <= im;
		end_of_set <= eos;
		do @(posedge clk); while (busy);
		sb.note(s, r, c, re, im, eos);
		sent++;
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int set_no;
		int n;
		sent = 0;
		gap_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		link_slot = '0;
		row = '0;
		col = '0;
		elem_re = '0;
		elem_im = '0;
		end_of_set = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full load: saturating extremes in the first links, random elsewhere
		for (int s = 0; s < LINKS; s++)
			for (int e = 0; e < 9; e++)
				send_elem(4'(s), 2'(e / 3), 2'(e % 3),
					s == 0 ? 32'h7fffffff : s == 1 ? 32'h80000000 : pick_value(),
					s == 0 ? 32'h80000000 : s == 1 ? 32'h7fffffff : pick_value(),
					s == LINKS - 1 && e == 8);
		drain();

		// out-of-range elements are dropped but their end mark still computes; valid ones between them load
		send_elem(4'd12, 2'd0, 2'd0, 32'h7fffffff, 32'h7fffffff, 1'b1);
		send_elem(4'd15, 2'd3, 2'd3, 32'h80000000, 32'h80000000, 1'b0);
		send_elem(4'd5, 2'd3, 2'd1, 32'h12345678, 32'h9abcdef0, 1'b1);
		send_elem(4'd7, 2'd1, 2'd3, 32'h0, 32'hffffffff, 1'b1);
		send_elem(4'd11, 2'd2, 2'd2, 32'h80000000, 32'h7fffffff, 1'b0);
		send_elem(4'd0, 2'd2, 2'd1, 32'h7fffffff, 32'h0, 1'b0);
		send_elem(4'd10, 2'd1, 2'd2, 32'h55555555, 32'haaaaaaaa, 1'b1);
		for (int e = 0; e < 9; e++)
			send_elem(4'd3, 2'(e / 3), 2'(e % 3), 32'h0, 32'h0, e == 8);
		drain();

		set_no = 0;
		while (sent < 360) begin
			case (set_no % 4)
				0: gap_pct = 0;
				1: gap_pct = 45;
				2: gap_pct = 0;
				default: gap_pct = 36;
			endcase
			n = $urandom_range(15, 40);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_elem(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)), $urandom, $urandom, 1'b0);
				else
					send_elem(4'($urandom_range(0, 11)), 2'($urandom_range(0, 2)),
						2'($urandom_range(0, 2)), pick_value(), pick_value(), 1'b0);
			end
			send_elem(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), pick_value(), pick_value(), 1'b1);
			if (set_no % 3 == 0) drain();
			set_no++;
		end

		drain();
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
